### hdl/imc_pkg.sv
// ----------------------------------------------------------------------------
// imc_pkg
// shared word type, action codes and pipeline stage record of the imu filter
// ----------------------------------------------------------------------------
package imc_pkg;

  localparam int WORD_W = 16;
  localparam int AXES   = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  // action codes carried by each input word
  typedef enum logic [1:0] {
    ACT_FILTER = 2'd0,
    ACT_LOAD   = 2'd1,
    ACT_CALIB  = 2'd2
  } action_t;

  // control record that travels down the pipeline next to the lane data
  typedef struct packed {
    logic                         valid;
    logic [1:0]                   action;
    logic [AXES-1:0][WORD_W-1:0]  gyro_load;
  } stage_t;

endpackage

### hdl/imu_moving_average_offset_calibration_unit.sv
// ----------------------------------------------------------------------------
// imu_moving_average_offset_calibration_unit
// six-axis moving-average filter with gyro bias calibration
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_ready is high: an action code and three
// accelerometer plus three gyro samples. A filter word writes each channel
// into its own ring of HISTORY_DEPTH entries and returns one result word with
// the six window means (truncated toward zero); the gyro means have the
// stored offsets subtracted and wrap to 16 bits. A load word sets the
// offsets from the gyro fields, a calibrate word zeroes them, skips
// SETTLE_SAMPLES results and then averages the next CALIB_SAMPLES gyro rates
// into new offsets; these words return nothing. Throughput is one word per
// cycle while nothing stalls, set by the six parallel lanes that each keep a
// running window sum (one read and one write of the ring per word). A result
// word passes the running sum, written at the accepting edge, then the mean
// multiply, mean sign and output register. When a calibration finishes, the
// final stage holds the next word through the multiply and apply states
// while the offsets are divided out by a reciprocal multiply. A waiting
// result stalls filter words and then the input; other words still pass.
// ----------------------------------------------------------------------------
module imu_moving_average_offset_calibration_unit #(
  parameter int  HISTORY_DEPTH  = 10,
  parameter int  SETTLE_SAMPLES = 50,
  parameter int  CALIB_SAMPLES  = 1000
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic signed [15:0]     in_accel_x,
  input  logic signed [15:0]     in_accel_y,
  input  logic signed [15:0]     in_accel_z,
  input  logic signed [15:0]     in_gyro_x,
  input  logic signed [15:0]     in_gyro_y,
  input  logic signed [15:0]     in_gyro_z,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [15:0]     out_avg_accel_x,
  output logic signed [15:0]     out_avg_accel_y,
  output logic signed [15:0]     out_avg_accel_z,
  output logic signed [15:0]     out_rate_x,
  output logic signed [15:0]     out_rate_y,
  output logic signed [15:0]     out_rate_z,
  output logic                   out_calibrating
);

  localparam int AddrW = $clog2(HISTORY_DEPTH);
  localparam logic [AddrW-1:0] LastPos = AddrW'(HISTORY_DEPTH - 1);

  // pipeline control: s1 holds the running sums, s2 the mean products,
  // s3 the signed means ahead of the merge stage
  imc_pkg::stage_t   s1_r, s2_r, s3_r;
  imc_pkg::stage_t   s1_in;
  logic              accept;
  logic              sample_wr;
  logic              merge_take;
  logic              free2, free3;
  logic              load2, load3;

  // shared ring write position; wrapped marks that every slot holds a sample
  logic [AddrW-1:0]  wp_r, wp_nxt;
  logic              wrapped_r, wrapped_nxt;

  imc_pkg::word_t    accel_in   [imc_pkg::AXES];
  imc_pkg::word_t    gyro_in    [imc_pkg::AXES];
  imc_pkg::word_t    accel_mean [imc_pkg::AXES];
  imc_pkg::word_t    gyro_mean  [imc_pkg::AXES];
  imc_pkg::word_t    res_accel  [imc_pkg::AXES];
  imc_pkg::word_t    res_rate   [imc_pkg::AXES];

  assign accel_in[0] = in_accel_x;
  assign accel_in[1] = in_accel_y;
  assign accel_in[2] = in_accel_z;
  assign gyro_in[0]  = in_gyro_x;
  assign gyro_in[1]  = in_gyro_y;
  assign gyro_in[2]  = in_gyro_z;

  // stages move independently so bubbles collapse
  assign free3    = !s3_r.valid || merge_take;
  assign load3    = s2_r.valid && free3;
  assign free2    = !s2_r.valid || free3;
  assign load2    = s1_r.valid && free2;
  assign in_ready = !s1_r.valid || free2;

  assign accept    = in_valid && in_ready;
  assign sample_wr = accept && (in_action == imc_pkg::ACT_FILTER);

  always_comb begin
    s1_in.valid  = 1'b1;
    s1_in.action = in_action;
    for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
      s1_in.gyro_load[ch] = gyro_in[ch];
    end
  end

  // write position advance, wrap back to the first slot
  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    if (sample_wr) begin
      if (wp_r == LastPos) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r      <= '0;
      s2_r      <= '0;
      s3_r      <= '0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
      if (accept) begin
        s1_r <= s1_in;
      end else if (load2) begin
        s1_r.valid <= 1'b0;
      end
      if (load2) begin
        s2_r <= s1_r;
      end else if (load3) begin
        s2_r.valid <= 1'b0;
      end
      if (load3) begin
        s3_r <= s2_r;
      end else if (merge_take) begin
        s3_r.valid <= 1'b0;
      end
    end
  end

  // six lanes: accelerometer and gyro channels
  for (genvar ch = 0; ch < imc_pkg::AXES; ch++) begin : g_accel
    imc_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (sample_wr),
      .wr_addr   (wp_r),
      .rd_addr   (wp_nxt),
      .old_valid (wrapped_r),
      .sample    (accel_in[ch]),
      .mul_en    (load2),
      .mean_en   (load3),
      .mean      (accel_mean[ch])
    );
  end

  for (genvar ch = 0; ch < imc_pkg::AXES; ch++) begin : g_gyro
    imc_lane #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .wr_en     (sample_wr),
      .wr_addr   (wp_r),
      .rd_addr   (wp_nxt),
      .old_valid (wrapped_r),
      .sample    (gyro_in[ch]),
      .mul_en    (load2),
      .mean_en   (load3),
      .mean      (gyro_mean[ch])
    );
  end

  // offsets, calibration and output register
  imc_merge #(
    .SETTLE_SAMPLES (SETTLE_SAMPLES),
    .CALIB_SAMPLES  (CALIB_SAMPLES)
  ) u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .item            (s3_r),
    .accel_mean      (accel_mean),
    .gyro_mean       (gyro_mean),
    .out_ready       (out_ready),
    .take            (merge_take),
    .out_valid       (out_valid),
    .out_accel       (res_accel),
    .out_rate        (res_rate),
    .out_calibrating (out_calibrating)
  );

  assign out_avg_accel_x = res_accel[0];
  assign out_avg_accel_y = res_accel[1];
  assign out_avg_accel_z = res_accel[2];
  assign out_rate_x      = res_rate[0];
  assign out_rate_y      = res_rate[1];
  assign out_rate_z      = res_rate[2];

`ifndef SYNTHESIS
  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LastPos)
    else $error("write position outside the ring");

  a_wrapped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("ring full flag dropped");

  a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_r.valid && !s2_r.valid && !s3_r.valid) |-> in_ready)
    else $error("empty pipeline refuses input word");
`endif

endmodule

### hdl/imc_lane.sv
// ----------------------------------------------------------------------------
// imc_lane
// one channel: history ring, running window sum and mean by reciprocal multiply
// ----------------------------------------------------------------------------
module imc_lane #(
  parameter int  HISTORY_DEPTH = 10,
  localparam int AddrW         = $clog2(HISTORY_DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [AddrW-1:0]   wr_addr,
  input  logic [AddrW-1:0]   rd_addr,
  input  logic               old_valid,
  input  imc_pkg::word_t     sample,
  input  logic               mul_en,
  input  logic               mean_en,
  output imc_pkg::word_t     mean
);

  localparam int SumW    = imc_pkg::WORD_W + $clog2(HISTORY_DEPTH);
  localparam int Shift   = SumW + $clog2(HISTORY_DEPTH);
  localparam int RecipW  = SumW + 2;
  localparam longint unsigned RecipFull =
    ((64'd1 << Shift) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipFull);
  localparam int ProdW   = SumW + RecipW;
  localparam int QuotW   = imc_pkg::WORD_W + 1;

  imc_pkg::word_t          ring_mem [HISTORY_DEPTH];
  imc_pkg::word_t          old_q_r;
  imc_pkg::word_t          old_word;
  logic signed [SumW-1:0]  sum_r;
  logic signed [SumW-1:0]  sum_nxt;
  logic [SumW-1:0]         mag;
  logic [ProdW-1:0]        prod_r;
  logic                    neg_r;
  logic [QuotW-1:0]        quot;
  logic [QuotW-1:0]        mean_full;
  imc_pkg::word_t          mean_r;

  assign old_word = old_valid ? old_q_r : '0;

  // drop the oldest word, add the new one
  assign sum_nxt = sum_r
                 - {{(SumW-imc_pkg::WORD_W){old_word[imc_pkg::WORD_W-1]}}, old_word}
                 + {{(SumW-imc_pkg::WORD_W){sample[imc_pkg::WORD_W-1]}}, sample};

  assign mag       = sum_r[SumW-1] ? (~sum_r + 1'b1) : sum_r;
  assign quot      = prod_r[Shift +: QuotW];
  assign mean_full = neg_r ? (~quot + 1'b1) : quot;
  assign mean      = mean_r;

  // ring memory, registered read of the slot about to be overwritten
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= sample;
    end
    old_q_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (wr_en) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mag * Recip;
      neg_r  <= sum_r[SumW-1];
    end
    if (mean_en) begin
      mean_r <= mean_full[imc_pkg::WORD_W-1:0];
    end
  end

endmodule

### hdl/imc_merge.sv
// ----------------------------------------------------------------------------
// imc_merge
// gyro offset subtraction, bias calibration and the output word register
// ----------------------------------------------------------------------------
module imc_merge #(
  parameter int SETTLE_SAMPLES = 50,
  parameter int CALIB_SAMPLES  = 1000
) (
  input  logic               clk,
  input  logic               rst_n,
  input  imc_pkg::stage_t    item,
  input  imc_pkg::word_t     accel_mean [imc_pkg::AXES],
  input  imc_pkg::word_t     gyro_mean  [imc_pkg::AXES],
  input  logic               out_ready,
  output logic               take,
  output logic               out_valid,
  output imc_pkg::word_t     out_accel  [imc_pkg::AXES],
  output imc_pkg::word_t     out_rate   [imc_pkg::AXES],
  output logic               out_calibrating
);

  localparam int CntW    = $clog2(SETTLE_SAMPLES + CALIB_SAMPLES + 1);
  localparam int CsumW   = imc_pkg::WORD_W + $clog2(CALIB_SAMPLES);
  localparam int Cshift  = CsumW + $clog2(CALIB_SAMPLES);
  localparam int CrecipW = CsumW + 2;
  localparam longint unsigned CrecipFull =
    ((64'd1 << Cshift) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
  localparam logic [CrecipW-1:0] Crecip = CrecipW'(CrecipFull);
  localparam int CprodW  = CsumW + CrecipW;
  localparam int QuotW   = imc_pkg::WORD_W + 1;
  localparam logic [CntW-1:0] SettleCnt = CntW'(SETTLE_SAMPLES);
  localparam logic [CntW-1:0] LastCnt   = CntW'(SETTLE_SAMPLES + CALIB_SAMPLES - 1);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_APPLY
  } div_state_t;

  div_state_t              div_state_r, div_state_nxt;
  logic                    active_r, active_nxt;
  logic [CntW-1:0]         count_r, count_nxt;
  imc_pkg::word_t          offsets_r [imc_pkg::AXES];
  imc_pkg::word_t          offsets_nxt [imc_pkg::AXES];
  logic signed [CsumW-1:0] sums_r [imc_pkg::AXES];
  logic signed [CsumW-1:0] sums_nxt [imc_pkg::AXES];
  logic signed [CsumW-1:0] sums_add [imc_pkg::AXES];
  imc_pkg::word_t          rate [imc_pkg::AXES];
  logic [CsumW-1:0]        cmag [imc_pkg::AXES];
  logic [CprodW-1:0]       cprod_r [imc_pkg::AXES];
  logic                    cneg_r [imc_pkg::AXES];
  logic [QuotW-1:0]        cquot [imc_pkg::AXES];
  logic [QuotW-1:0]        coff [imc_pkg::AXES];
  logic                    out_valid_r, out_valid_nxt;
  imc_pkg::word_t          out_accel_r [imc_pkg::AXES];
  imc_pkg::word_t          out_rate_r [imc_pkg::AXES];
  logic                    out_cal_r;
  logic                    filter_take;

  assign take = item.valid && (div_state_r == DIV_IDLE) &&
                ((item.action != imc_pkg::ACT_FILTER) || !out_valid_r || out_ready);
  assign filter_take = take && (item.action == imc_pkg::ACT_FILTER);

  always_comb begin
    for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
      rate[ch]     = gyro_mean[ch] - offsets_r[ch];
      sums_add[ch] = sums_r[ch] +
        {{(CsumW-imc_pkg::WORD_W){rate[ch][imc_pkg::WORD_W-1]}}, rate[ch]};
      cmag[ch]     = sums_r[ch][CsumW-1] ? (~sums_r[ch] + 1'b1) : sums_r[ch];
      cquot[ch]    = cprod_r[ch][Cshift +: QuotW];
      coff[ch]     = cneg_r[ch] ? (~cquot[ch] + 1'b1) : cquot[ch];
    end
  end

  always_comb begin
    div_state_nxt = div_state_r;
    active_nxt    = active_r;
    count_nxt     = count_r;
    offsets_nxt   = offsets_r;
    sums_nxt      = sums_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (take) begin
      unique case (item.action)
        imc_pkg::ACT_FILTER: begin
          out_valid_nxt = 1'b1;
          if (active_r) begin
            if (count_r >= SettleCnt) begin
              sums_nxt = sums_add;
            end
            if (count_r == LastCnt) begin
              active_nxt    = 1'b0;
              count_nxt     = '0;
              div_state_nxt = DIV_MUL;
            end else begin
              count_nxt = count_r + 1'b1;
            end
          end
        end
        imc_pkg::ACT_LOAD: begin
          for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
            offsets_nxt[ch] = item.gyro_load[ch];
            sums_nxt[ch]    = '0;
          end
          active_nxt = 1'b0;
          count_nxt  = '0;
        end
        imc_pkg::ACT_CALIB: begin
          for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
            offsets_nxt[ch] = '0;
            sums_nxt[ch]    = '0;
          end
          active_nxt = 1'b1;
          count_nxt  = '0;
        end
        default: begin
        end
      endcase
    end

    unique case (div_state_r)
      DIV_IDLE: begin
      end
      DIV_MUL: begin
        div_state_nxt = DIV_APPLY;
      end
      DIV_APPLY: begin
        for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
          offsets_nxt[ch] = coff[ch][imc_pkg::WORD_W-1:0];
        end
        div_state_nxt = DIV_IDLE;
      end
      default: begin
        div_state_nxt = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= DIV_IDLE;
      active_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
        offsets_r[ch] <= '0;
        sums_r[ch]    <= '0;
      end
    end else begin
      div_state_r <= div_state_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      offsets_r   <= offsets_nxt;
      sums_r      <= sums_nxt;
    end

    if (div_state_r == DIV_MUL) begin
      for (int ch = 0; ch < imc_pkg::AXES; ch++) begin
        cprod_r[ch] <= cmag[ch] * Crecip;
        cneg_r[ch]  <= sums_r[ch][CsumW-1];
      end
    end

    if (filter_take) begin
      out_accel_r <= accel_mean;
      out_rate_r  <= rate;
      out_cal_r   <= active_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accel       = out_accel_r;
  assign out_rate        = out_rate_r;
  assign out_calibrating = out_cal_r;

`ifndef SYNTHESIS
  a_no_take_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
    (div_state_r != DIV_IDLE) |-> !take)
    else $error("item taken while offset divide in progress");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LastCnt)
    else $error("calibration count past its end");

  a_count_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (count_r == '0))
    else $error("calibration count nonzero while idle");
`endif

endmodule
